// File: src/fbm_pkg.sv
package fbm_pkg;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_NOISE_SCALE  = 3'd2,
      CSR_TIME_OFFSET  = 3'd3,
      CSR_SEED         = 3'd4
   } csr_index_type;

   localparam logic [31:0] HASH_PX = 32'd73856093;
   localparam logic [31:0] HASH_PY = 32'd19349663;
   localparam logic [31:0] HASH_PZ = 32'd83492791;
   localparam logic [31:0] HASH_MIX = 32'd1274126177;

   typedef logic signed [15:0] q14_type;

   // quarter-wave sine, q1.14
   function automatic logic [14:0] sine_quarter(input logic [6:0] d);
      logic [14:0] r;
      case (d)
         7'd0: r = 15'd0;       7'd1: r = 15'd286;     7'd2: r = 15'd572;
         7'd3: r = 15'd857;     7'd4: r = 15'd1143;    7'd5: r = 15'd1428;
         7'd6: r = 15'd1713;    7'd7: r = 15'd1997;    7'd8: r = 15'd2280;
         7'd9: r = 15'd2563;    7'd10: r = 15'd2845;   7'd11: r = 15'd3126;
         7'd12: r = 15'd3406;   7'd13: r = 15'd3686;   7'd14: r = 15'd3964;
         7'd15: r = 15'd4240;   7'd16: r = 15'd4516;   7'd17: r = 15'd4790;
         7'd18: r = 15'd5063;   7'd19: r = 15'd5334;   7'd20: r = 15'd5604;
         7'd21: r = 15'd5871;   7'd22: r = 15'd6138;   7'd23: r = 15'd6402;
         7'd24: r = 15'd6664;   7'd25: r = 15'd6924;   7'd26: r = 15'd7182;
         7'd27: r = 15'd7438;   7'd28: r = 15'd7692;   7'd29: r = 15'd7943;
         7'd30: r = 15'd8192;   7'd31: r = 15'd8438;   7'd32: r = 15'd8682;
         7'd33: r = 15'd8923;   7'd34: r = 15'd9162;   7'd35: r = 15'd9397;
         7'd36: r = 15'd9630;   7'd37: r = 15'd9860;   7'd38: r = 15'd10087;
         7'd39: r = 15'd10311;  7'd40: r = 15'd10531;  7'd41: r = 15'd10749;
         7'd42: r = 15'd10963;  7'd43: r = 15'd11174;  7'd44: r = 15'd11381;
         7'd45: r = 15'd11585;  7'd46: r = 15'd11786;  7'd47: r = 15'd11982;
         7'd48: r = 15'd12176;  7'd49: r = 15'd12365;  7'd50: r = 15'd12551;
         7'd51: r = 15'd12733;  7'd52: r = 15'd12911;  7'd53: r = 15'd13085;
         7'd54: r = 15'd13255;  7'd55: r = 15'd13421;  7'd56: r = 15'd13583;
         7'd57: r = 15'd13741;  7'd58: r = 15'd13894;  7'd59: r = 15'd14044;
         7'd60: r = 15'd14189;  7'd61: r = 15'd14330;  7'd62: r = 15'd14466;
         7'd63: r = 15'd14598;  7'd64: r = 15'd14726;  7'd65: r = 15'd14849;
         7'd66: r = 15'd14968;  7'd67: r = 15'd15082;  7'd68: r = 15'd15191;
         7'd69: r = 15'd15296;  7'd70: r = 15'd15396;  7'd71: r = 15'd15491;
         7'd72: r = 15'd15582;  7'd73: r = 15'd15668;  7'd74: r = 15'd15749;
         7'd75: r = 15'd15826;  7'd76: r = 15'd15897;  7'd77: r = 15'd15964;
         7'd78: r = 15'd16026;  7'd79: r = 15'd16083;  7'd80: r = 15'd16135;
         7'd81: r = 15'd16182;  7'd82: r = 15'd16225;  7'd83: r = 15'd16262;
         7'd84: r = 15'd16294;  7'd85: r = 15'd16322;  7'd86: r = 15'd16344;
         7'd87: r = 15'd16362;  7'd88: r = 15'd16374;  7'd89: r = 15'd16382;
         7'd90: r = 15'd16384;
         default: r = 15'd0;
      endcase
      return r;
   endfunction

   // d in 0..449
   function automatic q14_type sin_deg(input logic [8:0] d_in);
      logic [8:0] d;
      logic [14:0] m;
      d = (d_in >= 9'd360) ? d_in - 9'd360 : d_in;
      if (d <= 9'd90) begin
         m = sine_quarter(d[6:0]);
         return q14_type'({1'b0, m});
      end else if (d <= 9'd180) begin
         m = sine_quarter(7'(9'd180 - d));
         return q14_type'({1'b0, m});
      end else if (d <= 9'd270) begin
         m = sine_quarter(7'(d - 9'd180));
         return -q14_type'({1'b0, m});
      end else begin
         m = sine_quarter(7'(9'd360 - d));
         return -q14_type'({1'b0, m});
      end
   endfunction

   // x mod 360 for x < 2^24, by reciprocal multiply with one correction
   function automatic logic [8:0] mod360(input logic [23:0] x);
      logic [47:0] p;
      logic [23:0] q;
      logic [32:0] qm;
      logic [23:0] r;
      p = 48'(x) * 48'd46603;
      q = 24'(p >> 24);
      qm = 33'(q) * 33'd360;
      r = x - qm[23:0];
      if (r >= 24'd360) r = r - 24'd360;
      return r[8:0];
   endfunction

endpackage

// File: src/fbm_divider.sv
// pipelined restoring divider, one quotient bit per stage
module fbm_divider #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quot
);
   logic [NUM_W:0]       valid_ff;
   logic [NUM_W-1:0]     num_ff [NUM_W+1];
   logic [DEN_W:0]       rem_ff [NUM_W+1];
   logic [DEN_W-1:0]     den_ff [NUM_W+1];

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= {valid_ff[NUM_W-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      num_ff[0] <= in_num;
      rem_ff[0] <= '0;
      den_ff[0] <= in_den;
   end

   for (genvar i = 0; i < NUM_W; i++) begin : g_step
      logic [DEN_W+1:0] trial;
      logic             ge;
      assign trial = {rem_ff[i], num_ff[i][NUM_W-1]};
      assign ge = trial >= {2'b0, den_ff[i]};
      always_ff @(posedge clock) begin
         rem_ff[i+1] <= ge ? (DEN_W+1)'(trial - {2'b0, den_ff[i]}) : trial[DEN_W:0];
         num_ff[i+1] <= {num_ff[i][NUM_W-2:0], ge};
         den_ff[i+1] <= den_ff[i];
      end
   end

   assign out_valid = valid_ff[NUM_W];
   assign out_quot = num_ff[NUM_W];
endmodule

// File: src/fbm_octave.sv
// one octave of 3-d gradient noise, pipelined
module fbm_octave #(
   parameter int FRAC_BITS = 16,
   parameter int CW = 64
) (
   input  logic                        clock,
   input  logic [CW-1:0]               x,
   input  logic [CW-1:0]               y,
   input  logic [CW-1:0]               z,
   input  logic [31:0]                 seed,
   output logic signed [FRAC_BITS+7:0] noise
);
   import fbm_pkg::*;

   localparam int F = FRAC_BITS;
   localparam int DW = F + 2;  // signed offset, -1..1
   localparam int NW = F + 8;  // corner / lerp values

   // stage 1: split, corner hashes part 1, smoothstep square
   logic [F-1:0]  fx1_ff, fy1_ff, fz1_ff;
   logic [31:0]   hp1_ff [8];
   logic [31:0]   seed1_ff;
   logic [F-1:0]  f2x1_ff, f2y1_ff, f2z1_ff;

   logic [31:0] ix, iy, iz;
   assign ix = 32'(x >> F);
   assign iy = 32'(y >> F);
   assign iz = 32'(z >> F);

   function automatic logic [F-1:0] fsq(input logic [F-1:0] f);
      logic [2*F-1:0] p;
      p = f * f;
      return p[2*F-1:F];
   endfunction

   always_ff @(posedge clock) begin
      fx1_ff <= x[F-1:0];
      fy1_ff <= y[F-1:0];
      fz1_ff <= z[F-1:0];
      seed1_ff <= seed;
      f2x1_ff <= fsq(x[F-1:0]);
      f2y1_ff <= fsq(y[F-1:0]);
      f2z1_ff <= fsq(z[F-1:0]);
   end

   for (genvar c = 0; c < 8; c++) begin : g_h1
      logic [31:0] cx, cy, cz;
      assign cx = ix + 32'(c & 1);
      assign cy = iy + 32'((c >> 1) & 1);
      assign cz = iz + 32'((c >> 2) & 1);
      always_ff @(posedge clock) begin
         hp1_ff[c] <= (cx * HASH_PX) ^ (cy * HASH_PY) ^ (cz * HASH_PZ);
      end
   end

   // stage 2: mix multiply, smoothstep
   logic [31:0]  hm2_ff [8];
   logic [F-1:0] fx2_ff, fy2_ff, fz2_ff;
   logic [F:0]   sx2_ff, sy2_ff, sz2_ff;

   function automatic logic [F:0] fsmooth(input logic [F-1:0] f2, input logic [F-1:0] f);
      logic [F+1:0]   t;
      logic [2*F+1:0] p;
      t = (F+2)'(3) << F;
      t = t - ((F+2)'(f) << 1);
      p = (2*F+2)'(f2) * (2*F+2)'(t);
      return (F+1)'(p >> F);
   endfunction

   always_ff @(posedge clock) begin
      fx2_ff <= fx1_ff;
      fy2_ff <= fy1_ff;
      fz2_ff <= fz1_ff;
      sx2_ff <= fsmooth(f2x1_ff, fx1_ff);
      sy2_ff <= fsmooth(f2y1_ff, fy1_ff);
      sz2_ff <= fsmooth(f2z1_ff, fz1_ff);
   end

   for (genvar c = 0; c < 8; c++) begin : g_h2
      logic [31:0] h;
      assign h = hp1_ff[c] ^ seed1_ff;
      always_ff @(posedge clock) begin
         hm2_ff[c] <= (h ^ (h >> 13)) * HASH_MIX;
      end
   end

   // stage 3: angles; stage 4: trig products
   logic [8:0]   th3_ff [8], ph3_ff [8];
   q14_type      st4_ff [8], gz4_ff [8];
   logic signed [31:0] px4_ff [8], py4_ff [8];
   logic [F-1:0] fx3_ff, fy3_ff, fz3_ff, fx4_ff, fy4_ff, fz4_ff;
   logic [F:0]   sx3_ff, sy3_ff, sz3_ff, sx4_ff, sy4_ff, sz4_ff;

   always_ff @(posedge clock) begin
      fx3_ff <= fx2_ff; fy3_ff <= fy2_ff; fz3_ff <= fz2_ff;
      sx3_ff <= sx2_ff; sy3_ff <= sy2_ff; sz3_ff <= sz2_ff;
      fx4_ff <= fx3_ff; fy4_ff <= fy3_ff; fz4_ff <= fz3_ff;
      sx4_ff <= sx3_ff; sy4_ff <= sy3_ff; sz4_ff <= sz3_ff;
   end

   for (genvar c = 0; c < 8; c++) begin : g_ang
      q14_type st, cp, sp;
      assign st = sin_deg(th3_ff[c]);
      assign cp = sin_deg(ph3_ff[c] + 9'd90);
      assign sp = sin_deg(ph3_ff[c]);
      always_ff @(posedge clock) begin
         st4_ff[c] <= st;
         gz4_ff[c] <= sin_deg(th3_ff[c] + 9'd90);
         px4_ff[c] <= 32'(st) * 32'(cp);
         py4_ff[c] <= 32'(st) * 32'(sp);
      end
   end

   // stage 5: gradient, offsets; stage 6: dot products
   q14_type gx5_ff [8], gy5_ff [8], gz5_ff [8];
   logic signed [DW-1:0] dx5_ff [8], dy5_ff [8], dz5_ff [8];
   logic [F:0] sx5_ff, sy5_ff, sz5_ff;
   logic signed [DW+15:0] tx6_ff [8], ty6_ff [8], tz6_ff [8];
   logic [F:0] sx6_ff, sy6_ff, sz6_ff;

   for (genvar c = 0; c < 8; c++) begin : g_grad
      logic signed [31:0] rx, ry;
      assign rx = px4_ff[c] + 32'sd8192;
      assign ry = py4_ff[c] + 32'sd8192;
      always_ff @(posedge clock) begin
         gx5_ff[c] <= q14_type'(rx >>> 14);
         gy5_ff[c] <= q14_type'(ry >>> 14);
         gz5_ff[c] <= gz4_ff[c];
         dx5_ff[c] <= ((c & 1) != 0) ? $signed({2'b0, fx4_ff}) - $signed(DW'(1) << F)
                                     : $signed({2'b0, fx4_ff});
         dy5_ff[c] <= ((c & 2) != 0) ? $signed({2'b0, fy4_ff}) - $signed(DW'(1) << F)
                                     : $signed({2'b0, fy4_ff});
         dz5_ff[c] <= ((c & 4) != 0) ? $signed({2'b0, fz4_ff}) - $signed(DW'(1) << F)
                                     : $signed({2'b0, fz4_ff});
         tx6_ff[c] <= (DW+16)'(gx5_ff[c]) * (DW+16)'(dx5_ff[c]);
         ty6_ff[c] <= (DW+16)'(gy5_ff[c]) * (DW+16)'(dy5_ff[c]);
         tz6_ff[c] <= (DW+16)'(gz5_ff[c]) * (DW+16)'(dz5_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      sx5_ff <= sx4_ff; sy5_ff <= sy4_ff; sz5_ff <= sz4_ff;
      sx6_ff <= sx5_ff; sy6_ff <= sy5_ff; sz6_ff <= sz5_ff;
   end

   // stage 7: corner values
   logic signed [NW-1:0] n7_ff [8];
   logic [F:0] sx7_ff, sy7_ff, sz7_ff;
   for (genvar c = 0; c < 8; c++) begin : g_corner
      logic signed [DW+17:0] s;
      assign s = (DW+18)'(tx6_ff[c]) + (DW+18)'(ty6_ff[c]) + (DW+18)'(tz6_ff[c])
               + (DW+18)'(8192);
      always_ff @(posedge clock) n7_ff[c] <= NW'(s >>> 14);
   end
   always_ff @(posedge clock) begin
      sx7_ff <= sx6_ff; sy7_ff <= sy6_ff; sz7_ff <= sz6_ff;
   end

   function automatic logic signed [NW-1:0] lerp_fn(input logic signed [NW-1:0] a,
         input logic signed [NW-1:0] b, input logic [F:0] s);
      logic signed [NW:0]     d;
      logic signed [NW+F+2:0] p;
      d = (NW+1)'(b) - (NW+1)'(a);
      p = (NW+F+3)'(d) * $signed({2'b0, s});
      return NW'((NW+F+3)'(a) + (p >>> F));
   endfunction

   // stages 8-10: lerp in x, y, z
   logic signed [NW-1:0] a8_ff [4], b9_ff [2];
   logic [F:0] sy8_ff, sz8_ff, sz9_ff;
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) a8_ff[i] <= lerp_fn(n7_ff[2*i], n7_ff[2*i+1], sx7_ff);
      sy8_ff <= sy7_ff; sz8_ff <= sz7_ff;
      for (int i = 0; i < 2; i++) b9_ff[i] <= lerp_fn(a8_ff[2*i], a8_ff[2*i+1], sy8_ff);
      sz9_ff <= sz8_ff;
      noise <= lerp_fn(b9_ff[0], b9_ff[1], sz9_ff);
   end

   // stage 3 angles over the full 32-bit hash, folded with 2^16 mod 360 = 16
   for (genvar c = 0; c < 8; c++) begin : g_mod
      logic [31:0] h;
      logic [8:0]  rt, rp;
      assign h = hm2_ff[c] ^ (hm2_ff[c] >> 16);
      assign rt = mod360(24'(h[31:16]) * 24'd16 + 24'(h[15:0]));
      assign rp = mod360(24'(h[31:24]) * 24'd16 + 24'(h[23:8]));
      always_ff @(posedge clock) begin
         th3_ff[c] <= rt;
         ph3_ff[c] <= rp;
      end
   end
endmodule

// File: src/fbm_gradient_noise_pixel.sv
// Pixel noise generator: one pixel may start every clock cycle and busy is
// always low. The result is on rsp_* with rsp_valid high for one cycle, after
// one input stage, FRAC_BITS + 21 divider stages for the frame-size
// normalization, ten octave stages, then the octave sum, the 0..255 scaling
// and the output register. The receiver cannot stall, so results must be
// taken when rsp_valid is high.
module fbm_gradient_noise_pixel #(
   parameter int OCTAVES = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_pixel_x,
   input  logic [11:0] req_pixel_y,
   output logic        rsp_valid,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [fbm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_data
);
   import fbm_pkg::*;

   localparam int F = FRAC_BITS;
   localparam int NUM_W = 28 + F - 8;
   localparam int CW = 64;
   localparam int NW = F + 8;
   localparam int OLAT = 10;
   localparam int AW = NW + OCTAVES + 1;

   logic [12:0] width_ff, height_ff;
   logic [15:0] scale_ff;
   logic [31:0] time_ff, seed_ff;

   assign csr_ready = 1'b1;
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 13'd256;
         height_ff <= 13'd256;
         scale_ff <= 16'd256;
         time_ff <= '0;
         seed_ff <= 32'd1337;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_ff <= csr_data[12:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_data[12:0];
            CSR_NOISE_SCALE:  scale_ff <= csr_data[15:0];
            CSR_TIME_OFFSET:  time_ff <= csr_data;
            CSR_SEED:         seed_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 0: product, divisor
   logic        v0_ff;
   logic [27:0] nx0_ff, ny0_ff;
   logic [12:0] w0_ff, h0_ff;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else v0_ff <= start;
      nx0_ff <= 28'(req_pixel_x) * 28'(scale_ff);
      ny0_ff <= 28'(req_pixel_y) * 28'(scale_ff);
      w0_ff <= (width_ff == '0) ? 13'd1 : width_ff;
      h0_ff <= (height_ff == '0) ? 13'd1 : height_ff;
   end

   logic dvx, dvy;
   logic [NUM_W-1:0] qx, qy;
   fbm_divider #(.NUM_W(NUM_W), .DEN_W(13)) u_divx (
      .clock, .reset, .in_valid(v0_ff), .in_num(NUM_W'(nx0_ff) << (F - 8)),
      .in_den(w0_ff), .out_valid(dvx), .out_quot(qx));
   fbm_divider #(.NUM_W(NUM_W), .DEN_W(13)) u_divy (
      .clock, .reset, .in_valid(v0_ff), .in_num(NUM_W'(ny0_ff) << (F - 8)),
      .in_den(h0_ff), .out_valid(dvy), .out_quot(qy));

   logic signed [NW-1:0] n_oct [OCTAVES];
   for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
      fbm_octave #(.FRAC_BITS(F), .CW(CW)) u_oct (
         .clock,
         .x(CW'(qx) << k),
         .y(CW'(qy) << k),
         .z((F >= 17) ? (CW'(time_ff) << k) << (F >= 17 ? F - 17 : 0)
                      : (CW'(time_ff) << k) >> (F < 17 ? 17 - F : 0)),
         .seed(seed_ff),
         .noise(n_oct[k]));
   end

   logic [OLAT-1:0] vpipe_ff;
   always_ff @(posedge clock) begin
      if (reset) vpipe_ff <= '0;
      else vpipe_ff <= {vpipe_ff[OLAT-2:0], dvx & dvy};
   end

   // accumulate and normalize
   logic signed [AW+9:0] num_ff;
   logic                 vn_ff, vv_ff, vo_ff;
   logic signed [AW+1:0] acc;
   localparam logic [OCTAVES:0] M = (OCTAVES+1)'((1 << OCTAVES) - 1);
   always_comb begin
      acc = (AW+2)'(signed'({1'b0, M})) <<< F;
      for (int k = 0; k < OCTAVES; k++)
         acc = acc + ((AW+2)'(n_oct[k]) <<< (OCTAVES - 1 - k));
   end

   // v = floor((num >> (F+1)) / M) by reciprocal multiply, saturated at 255
   localparam int TW = AW + 8 - F;
   localparam int RSH = 26;
   localparam logic [RSH:0] RECIP = (RSH+1)'((64'd1 << RSH) / 64'(M) + 64'd1);
   logic [TW-1:0] t;
   logic [42:0]   prod;
   logic [7:0]    v;
   logic [7:0]    v_ff;
   always_comb begin
      t = num_ff[AW+8:F+1];
      prod = 43'(t[15:0]) * 43'(RECIP);
      if (num_ff <= 0) v = 8'd0;
      else if (t >= (TW'(M) << 8)) v = 8'd255;
      else v = prod[RSH+7:RSH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff <= 1'b0;
         vv_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         vn_ff <= vpipe_ff[OLAT-1];
         vv_ff <= vn_ff;
         vo_ff <= vv_ff;
      end
      num_ff <= (AW+10)'(acc) * (AW+10)'(255);
      v_ff <= v;
   end

   // 256 folds to 1 modulo 255
   logic [12:0] r23;
   logic [8:0]  rfold;
   logic [7:0]  red;
   always_comb begin
      r23 = 13'(v_ff) * 13'd23;
      rfold = 9'(r23[12:8]) + 9'(r23[7:0]);
      red = (rfold >= 9'd255) ? 8'(rfold - 9'd255) : rfold[7:0];
   end

   always_ff @(posedge clock) begin
      rsp_green <= v_ff;
      rsp_blue <= v_ff;
      rsp_red <= red;
   end
   assign rsp_valid = vo_ff;
endmodule

// File: tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fbm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd5;
   localparam int OCTAVE_COUNT = 4;
   localparam int FRAC = 16;
   localparam int PIPE_DRAIN = 120;
   localparam int SINE_TBL [91] = '{
      0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
      2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
      5604, 5871, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
      8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
      10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
      12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
      14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
      15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
      16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
      16384};

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [11:0] req_pixel_x;
   logic [11:0] req_pixel_y;
   logic        rsp_valid;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_data;

   logic [12:0] frame_w;
   logic [12:0] frame_h;
   logic [15:0] scale_q8;
   logic [31:0] time_q16;
   logic [31:0] hash_seed;

   rgb_type pixel_queue[$];
   int      send_idle_pct;
   int      mismatch_count;
   int      pixel_count;
   int      csr_count;
   int      checked_count;

   fbm_gradient_noise_pixel dut (.*);

   always #4 clock = ~clock;

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   function automatic longint sin_q14(int d);
      d = d % 360;
      if (d <= 90) return SINE_TBL[d];
      if (d <= 180) return SINE_TBL[180 - d];
      if (d <= 270) return -SINE_TBL[d - 180];
      return -SINE_TBL[360 - d];
   endfunction

   function automatic longint corner_dot(logic [31:0] ix, logic [31:0] iy,
                                         logic [31:0] iz, longint dx, longint dy,
                                         longint dz);
      logic [31:0] h;
      int th, ph;
      longint st, gx, gy, gz;
      h = (ix * HASH_PX) ^ (iy * HASH_PY) ^ (iz * HASH_PZ) ^ hash_seed;
      h = (h ^ (h >> 13)) * HASH_MIX;
      h = h ^ (h >> 16);
      th = int'(h % 360);
      ph = int'((h >> 8) % 360);
      st = sin_q14(th);
      gx = (st * sin_q14(ph + 90) + 8192) >>> 14;
      gy = (st * sin_q14(ph) + 8192) >>> 14;
      gz = sin_q14(th + 90);
      return (gx * dx + gy * dy + gz * dz + 8192) >>> 14;
   endfunction

   function automatic longint smoothstep(longint f);
      longint f2;
      f2 = (f * f) >>> FRAC;
      return (f2 * (3 * 65536 - 2 * f)) >>> FRAC;
   endfunction

   function automatic longint blend(longint a, longint b, longint s);
      return a + (((b - a) * s) >>> FRAC);
   endfunction

   function automatic longint lattice_noise(longint unsigned x, longint unsigned y,
                                            longint unsigned z);
      longint f[3];
      longint s[3];
      logic [31:0] ix, iy, iz;
      longint n[8];
      longint a[4];
      f[0] = longint'(x & 64'hFFFF);
      f[1] = longint'(y & 64'hFFFF);
      f[2] = longint'(z & 64'hFFFF);
      ix = 32'(x >> FRAC);
      iy = 32'(y >> FRAC);
      iz = 32'(z >> FRAC);
      for (int i = 0; i < 3; i++) s[i] = smoothstep(f[i]);
      for (int c = 0; c < 8; c++) begin
         n[c] = corner_dot(ix + c[0], iy + c[1], iz + c[2],
                           f[0] - (c[0] ? 65536 : 0), f[1] - (c[1] ? 65536 : 0),
                           f[2] - (c[2] ? 65536 : 0));
      end
      for (int i = 0; i < 4; i++) a[i] = blend(n[2*i], n[2*i+1], s[0]);
      return blend(blend(a[0], a[1], s[1]), blend(a[2], a[3], s[1]), s[2]);
   endfunction

   function automatic rgb_type shade_pixel(logic [11:0] px, logic [11:0] py);
      longint unsigned w, h, bx, by, z;
      longint acc, num, v;
      rgb_type r;
      w = (frame_w == 0) ? 1 : frame_w;
      h = (frame_h == 0) ? 1 : frame_h;
      bx = ((64'(px) * scale_q8) << 8) / w;
      by = ((64'(py) * scale_q8) << 8) / h;
      acc = 0;
      for (int k = 0; k < OCTAVE_COUNT; k++) begin
         z = (64'(time_q16) << k) >> 1;
         acc += lattice_noise(bx << k, by << k, z) * (64'sd1 << (OCTAVE_COUNT - 1 - k));
      end
      num = 255 * (acc + 15 * 65536);
      if (num <= 0) v = 0;
      else begin
         v = num / (15 * 131072);
         if (v > 255) v = 255;
      end
      r.green = 8'(v);
      r.blue = 8'(v);
      r.red = 8'((v * 23) % 255);
      return r;
   endfunction

   task automatic send_pixel(logic [11:0] px, logic [11:0] py);
      logic b;
      if ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      do begin
         @(negedge clock);
         b = busy;
         @(posedge clock);
      end while (b);
      pixel_queue.push_back(shade_pixel(px, py));
      pixel_count++;
   endtask

   task automatic settle;
      start <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      logic r;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do begin
         @(negedge clock);
         r = csr_ready;
         @(posedge clock);
      end while (!r);
      csr_valid <= 1'b0;
      @(posedge clock);
      csr_count++;
      case (idx)
         CSR_FRAME_WIDTH:  frame_w = value[12:0];
         CSR_FRAME_HEIGHT: frame_h = value[12:0];
         CSR_NOISE_SCALE:  scale_q8 = value[15:0];
         CSR_TIME_OFFSET:  time_q16 = value;
         CSR_SEED:         hash_seed = value;
         default: ;
      endcase
   endtask

   task automatic write_frame(logic [31:0] w, logic [31:0] h, logic [31:0] sc,
                              logic [31:0] t, logic [31:0] sd);
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      write_csr(CSR_NOISE_SCALE, sc);
      write_csr(CSR_TIME_OFFSET, t);
      write_csr(CSR_SEED, sd);
   endtask

   always @(negedge clock) begin
      rgb_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_red, rsp_green, rsp_blue};
         checked_count++;
         if (pixel_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", got);
         end else begin
            want = pixel_queue.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: red %0d/%0d green %0d/%0d blue %0d/%0d (exp/got)",
                           want.red, got.red, want.green, got.green,
                           want.blue, got.blue);
            end
         end
      end
   end

   task automatic test_corner_pixels;
      send_pixel(12'd0, 12'd0);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'hFFF, 12'd0);
      send_pixel(12'd0, 12'hFFF);
      send_pixel(12'd255, 12'd128);
      send_pixel(12'hAAA, 12'h555);
      send_pixel(12'h555, 12'hAAA);
      settle();
   endtask

   task automatic test_register_extremes;
      write_frame(0, 0, 16'hFFFF, 32'hFFFF_FFFF, 0);
      send_pixel(12'hFFF, 12'h001);
      send_pixel(12'h001, 12'hFFF);
      settle();
      write_frame(4096, 4096, 0, 0, 32'hFFFF_FFFF);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'd7, 12'd3);
      settle();
      write_frame(32'hFFFF_FFFF, 8191, 65535, 32'h8000_0001, 32'h1234_5678);
      send_pixel(12'hFFF, 12'h800);
      send_pixel(12'd100, 12'd4000);
      settle();
      write_frame(1, 1, 65535, 32'h0001_8000, 1337);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'd1, 12'd0);
      settle();
      write_csr(CSR_UNUSED, 32'hDEAD_BEEF);
      write_csr(CSR_SPARE, 32'h0);
      write_frame(64, 48, 512, 32'h0003_4000, 32'hCAFE_0000);
      for (int i = 0; i < 6; i++) send_pixel(12'($urandom_range(63)), 12'($urandom_range(47)));
      settle();
   endtask

   task automatic test_random_frames(int idle_pct, int count);
      logic [31:0] w, h;
      send_idle_pct = idle_pct;
      for (int blk = 0; blk < count / 80; blk++) begin
         w = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 4096);
         h = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 4096);
         write_frame(w, h, ($urandom_range(3) == 0) ? $urandom : $urandom_range(64, 1024),
                     $urandom, $urandom);
         if ($urandom_range(4) == 0) write_csr(3'($urandom_range(5, 7)), $urandom);
         for (int i = 0; i < 80; i++) begin
            if ($urandom_range(1) == 0)
               send_pixel(12'($urandom), 12'($urandom));
            else
               send_pixel(12'($urandom % (w[12:0] == 0 ? 1 : w[12:0])),
                          12'($urandom % (h[12:0] == 0 ? 1 : h[12:0])));
         end
         settle();
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      frame_w = 13'd256;
      frame_h = 13'd256;
      scale_q8 = 16'd256;
      time_q16 = 32'd0;
      hash_seed = 32'd1337;
      send_idle_pct = 0;
      mismatch_count = 0;
      pixel_count = 0;
      csr_count = 0;
      checked_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_pixels();
      test_register_extremes();
      test_random_frames(33, 640);
      test_random_frames(77, 640);
      test_random_frames(0, 640);
      settle();
      $display("covered %0d pixels and %0d register writes, %0d results checked",
               pixel_count, csr_count, checked_count);
      $display("frame sizes, scales, times and seeds swept including zero and full-range values");
      if (mismatch_count == 0 && pixel_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count, pixel_queue.size());
         $display("status: fail");
      end
      $finish;
   end
endmodule
